### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, masked while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

### hdl/pwa_pkg.sv
`timescale 1ns / 1ps

package pwa_pkg;

	// fixed field widths
	localparam int OPCODE_W = 2;
	localparam int PING_W   = 16;
	localparam int FILL_W   = 6;

	// stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_BEGIN = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_END   = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [PING_W-1:0]   ping_ms;
	} pwa_item_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill_count;
		logic [PING_W-1:0] instant_ping;
		logic [PING_W-1:0] average_ping;
	} pwa_result_t;

endpackage

### hdl/ping_window_average_unit.sv
`timescale 1ns / 1ps
// The core works on one item at a time through a bit-serial divider, one quotient bit per cycle,
// and takes no new item until the result of the last one has been loaded for output. A two-item
// input queue takes up to two items while the back end works or a result waits. Reset (arst_n
// low) clears the window state; ring entries are not cleared, unwritten ones are masked by the fill count.

module ping_window_average_unit #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [1:0] opcode, [17:2] ping_ms, [23:18] zero
	input  logic [pwa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [15:0] average_ping, [31:16] instant_ping, [37:32] fill_count, [39:38] zero
	output logic [pwa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	import pwa_pkg::*;

	pwa_item_t   in_item;
	pwa_item_t   queued_item;
	logic        queued_valid;
	logic        queued_ready;
	pwa_result_t result;

	// unpack input item
	assign in_item.opcode  = s_axis_tdata[OPCODE_W-1:0];
	assign in_item.ping_ms = s_axis_tdata[OPCODE_W+PING_W-1:OPCODE_W];

	pwa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.out_valid (queued_valid),
		.out_ready (queued_ready),
		.out_item  (queued_item)
	);

	pwa_core #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (queued_valid),
		.item_ready (queued_ready),
		.item       (queued_item),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.result     (result)
	);

	// pack result item
	assign m_axis_tdata = {2'b00, result.fill_count, result.instant_ping, result.average_ping};

endmodule

### hdl/pwa_ram.sv
`timescale 1ns / 1ps

module pwa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/pwa_div.sv
`timescale 1ns / 1ps

module pwa_div #(
	parameter int DIVIDEND_W = 21,
	parameter int DIVISOR_W  = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;

	logic [DIVISOR_W:0]    rem_shift;
	logic [DIVISOR_W+1:0]  diff;
	logic                  fits;

	// one restoring step: shift in next dividend bit, try the subtract
	always_comb begin
		rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
		diff      = {1'b0, rem_shift} - {2'b00, div_q};
		fits      = !diff[DIVISOR_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, quotient bits enter from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hdl/pwa_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pwa_pkg::pwa_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output pwa_pkg::pwa_item_t out_item
);

	import pwa_pkg::*;

	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	pwa_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       push;
	logic       pop;

	assign in_ready  = (level_q != QUEUE_DEPTH);
	assign out_valid = (level_q != 2'd0);
	assign out_item  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

	// item storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	`ASSERT_NEVER(a_level_max, clk, arst_n, level_q > QUEUE_DEPTH, "queue level overflow")
	`ASSERT_CLK(a_ptr_level, clk, arst_n, (level_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q), "empty queue with unequal pointers")

endmodule

### hdl/pwa_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwa_core #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  pwa_pkg::pwa_item_t   item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output pwa_pkg::pwa_result_t result
);

	import pwa_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = PING_W + $clog2(WINDOW_DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [OPCODE_W-1:0] op_q;
	logic [PING_W-1:0]   ping_q;

	// window state
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PING_W-1:0]   latest_q;
	logic                batch_q;
	logic [SLOT_W-1:0]   slot_d;
	logic [CNT_W-1:0]    count_d;
	logic [SUM_W-1:0]    sum_d;
	logic [PING_W-1:0]   latest_d;
	logic                batch_d;

	logic                res_valid_q;
	pwa_result_t         result_q;

	// ring access
	logic                full;
	logic [SLOT_W-1:0]   prev_slot;
	logic                rd_en;
	logic [SLOT_W-1:0]   rd_addr;
	logic [PING_W-1:0]   rd_data;
	logic                store_en;
	logic [PING_W-1:0]   store_val;
	logic [PING_W-1:0]   evicted;

	logic                div_start;
	logic                div_done;
	logic [SUM_W-1:0]    quotient;
	logic                load_out;

	assign full      = (count_q == CNT_W'(WINDOW_DEPTH));
	assign prev_slot = (slot_q == '0) ? SLOT_W'(WINDOW_DEPTH - 1) : slot_q - 1'b1;
	assign evicted   = full ? rd_data : '0;

	assign item_ready = (state_q == ST_IDLE);
	assign rd_en      = (state_q == ST_READ);
	// an empty batch end restores the newest entry, everything else reads the slot that a store would replace
	assign rd_addr    = (op_q == OP_END && latest_q == '0) ? prev_slot : slot_q;
	assign div_start  = (state_q == ST_START);
	assign load_out   = (state_q == ST_OUT) && (!res_valid_q || res_ready);

	// opcode execution
	always_comb begin
		store_en  = 1'b0;
		store_val = ping_q;
		slot_d    = slot_q;
		count_d   = count_q;
		sum_d     = sum_q;
		latest_d  = latest_q;
		batch_d   = batch_q;
		unique case (op_q)
			OP_ADD: begin
				if (batch_q) begin
					if (latest_q == '0 || ping_q < latest_q) begin
						latest_d = ping_q;
					end
				end else begin
					store_en  = 1'b1;
					store_val = ping_q;
				end
			end
			OP_BEGIN: begin
				batch_d  = 1'b1;
				latest_d = '0;
			end
			OP_END: begin
				if (batch_q) begin
					batch_d = 1'b0;
					if (latest_q == '0) begin
						if (count_q != '0) begin
							latest_d = rd_data;
						end
					end else begin
						store_en  = 1'b1;
						store_val = latest_q;
					end
				end
			end
			OP_READ: begin
			end
		endcase
		if (store_en) begin
			sum_d    = sum_q - SUM_W'(evicted) + SUM_W'(store_val);
			latest_d = store_val;
			count_d  = full ? count_q : count_q + 1'b1;
			slot_d   = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (item_valid) state_d = ST_READ;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_OUT;
			ST_OUT:   if (load_out) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_READ;
			slot_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			latest_q    <= '0;
			batch_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_valid && item_ready) begin
				op_q <= item.opcode;
			end
			if (state_q == ST_EXEC) begin
				slot_q   <= slot_d;
				count_q  <= count_d;
				sum_q    <= sum_d;
				latest_q <= latest_d;
				batch_q  <= batch_d;
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			ping_q <= item.ping_ms;
		end
		if (load_out) begin
			result_q.average_ping <= (count_q == '0) ? '0 : quotient[PING_W-1:0];
			result_q.instant_ping <= (count_q == '0) ? '0 : latest_q;
			result_q.fill_count   <= FILL_W'(count_q);
		end
	end

	assign res_valid = res_valid_q;
	assign result    = result_q;

	pwa_ram #(
		.WIDTH (PING_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   ((state_q == ST_EXEC) && store_en),
		.wr_addr (slot_q),
		.wr_data (store_val),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pwa_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	`ASSERT_NEVER(a_count_max, clk, arst_n, count_q > CNT_W'(WINDOW_DEPTH), "fill count above window depth")
	`ASSERT_CLK(a_empty_sum, clk, arst_n, (count_q == '0) |-> (sum_q == '0), "nonzero sum with empty window")
	`ASSERT_CLK(a_div_done, clk, arst_n, div_done |-> (state_q == ST_DIV), "divider finished outside divide state")

endmodule
